>>> rtl/aas_pkg.sv
// shared constants for the annealing acceptance scheduler
package aas_pkg;

    // exponential table: round(65536*exp(-k/256)), k indexes the ratio
    localparam int unsigned EXP_DEPTH  = 4096;
    localparam int unsigned EXP_IDX_W  = $clog2(EXP_DEPTH);
    localparam int unsigned EXP_FRAC_W = 8;
    localparam int unsigned SAT_SHIFT  = EXP_IDX_W - EXP_FRAC_W;
    localparam logic [EXP_IDX_W-1:0] EXP_IDX_MAX = EXP_IDX_W'(EXP_DEPTH - 1);

    // q2.62 seed for the table build: exp(-1/256) from an eight-term series
    localparam logic [63:0] EXP_ONE  = 64'd1 << 62;
    localparam logic [63:0] EXP_T1   = EXP_ONE / 64'd256;
    localparam logic [63:0] EXP_T2   = EXP_T1 / 64'd512;
    localparam logic [63:0] EXP_T3   = EXP_T2 / 64'd768;
    localparam logic [63:0] EXP_T4   = EXP_T3 / 64'd1024;
    localparam logic [63:0] EXP_T5   = EXP_T4 / 64'd1280;
    localparam logic [63:0] EXP_T6   = EXP_T5 / 64'd1536;
    localparam logic [63:0] EXP_T7   = EXP_T6 / 64'd1792;
    localparam logic [63:0] EXP_T8   = EXP_T7 / 64'd2048;
    localparam logic [63:0] EXP_STEP = EXP_ONE - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4
                                     - EXP_T5 + EXP_T6 - EXP_T7 + EXP_T8;
    // rounding to 16 fraction bits out of 62
    localparam logic [63:0] EXP_HALF = 64'd1 << 45;

    // serial multiplier and divider step counts
    localparam logic [5:0] FILL_MUL_STEPS = 6'd62;
    localparam logic [5:0] COOL_MUL_STEPS = 6'd16;
    localparam logic [5:0] DIV_STEPS      = 6'(EXP_IDX_W);

    localparam logic [2:0] IDLE_ROUND_LIMIT = 3'd5;
    localparam logic [2:0] IDLE_ROUND_SAT   = 3'd7;

    // configuration register indexes
    localparam logic [2:0] CFG_START_TEMP  = 3'd0;
    localparam logic [2:0] CFG_STOP_TEMP   = 3'd1;
    localparam logic [2:0] CFG_COOL_RATE   = 3'd2;
    localparam logic [2:0] CFG_TRIALS_LIM  = 3'd3;
    localparam logic [2:0] CFG_CHANGES_LIM = 3'd4;

    // configuration reset values
    localparam logic [31:0] RST_START_TEMP  = 32'd1000000;
    localparam logic [31:0] RST_STOP_TEMP   = 32'd1;
    localparam logic [15:0] RST_COOL_RATE   = 16'd58982;
    localparam logic [19:0] RST_TRIALS_LIM  = 20'd100000;
    localparam logic [19:0] RST_CHANGES_LIM = 20'd1000;

    // item commands
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_TRIAL   = 1'b1;

endpackage

>>> rtl/annealing_acceptance_scheduler_unit.sv
// simulated annealing acceptance scheduler: metropolis decision and geometric cooling
//
// After reset the block builds its 4096-entry exponential table with a bit-serial
// q2.62 multiplier, one entry per multiply; s_ready stays low during the build
// while configuration writes are taken as usual. Then one item is handled at a time.
// A restart or a trial after the run has finished goes from acceptance straight to
// the output state; a trial with a negative energy change passes through the count
// state first. Other trials run a bit-serial divider (12 steps, one ratio bit each)
// and a table read, or only the table read when the ratio saturates and the divider
// is skipped. A trial that closes a round adds a 16-step bit-serial multiply for
// cooling and a check state. The next item is taken at the earliest in the cycle
// after the result register is loaded. The result register holds one finished item,
// so the next item is taken while the last result waits; a finished item that finds
// the result register still full waits until it drains.
module annealing_acceptance_scheduler_unit
    import aas_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic signed [31:0] s_energy_change,
    input  logic [16:0]        s_rand_value,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_accept,
    output logic [31:0]        m_temperature_used,
    output logic               m_round_end,
    output logic [19:0]        m_round_trials,
    output logic [19:0]        m_round_changes,
    output logic               m_run_done
);

    localparam int unsigned DIV_W = 32 + EXP_IDX_W;

    typedef enum logic [3:0] {
        ST_FILL_WR,
        ST_FILL_MUL,
        ST_IDLE,
        ST_RATIO,
        ST_DIV,
        ST_ROM_RD,
        ST_CMP,
        ST_COUNT,
        ST_COOL,
        ST_CHECK,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] start_temp_reg, start_temp_next;
    logic [31:0] stop_temp_reg, stop_temp_next;
    logic [15:0] cool_rate_reg, cool_rate_next;
    logic [19:0] trials_lim_reg, trials_lim_next;
    logic [19:0] changes_lim_reg, changes_lim_next;

    logic [31:0] temp_reg, temp_next;
    logic [19:0] trial_cnt_reg, trial_cnt_next;
    logic [19:0] change_cnt_reg, change_cnt_next;
    logic [2:0]  idle_rounds_reg, idle_rounds_next;
    logic        finished_reg, finished_next;

    logic [30:0] delta_reg, delta_next;
    logic [16:0] rnd_reg, rnd_next;

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-2:0]     div_reg, div_next;
    logic [EXP_IDX_W-1:0] ratio_reg, ratio_next;
    logic [5:0]           step_cnt_reg, step_cnt_next;

    logic [62:0]          p_reg, p_next;
    logic [EXP_IDX_W-1:0] fill_idx_reg, fill_idx_next;
    logic [62:0]          mul_acc_reg, mul_acc_next;
    logic [61:0]          mul_b_reg, mul_b_next;

    logic        res_accept_reg, res_accept_next;
    logic [31:0] res_temp_reg, res_temp_next;
    logic        res_round_end_reg, res_round_end_next;
    logic [19:0] res_trials_reg, res_trials_next;
    logic [19:0] res_changes_reg, res_changes_next;
    logic        res_done_reg, res_done_next;

    logic        m_valid_reg, m_valid_next;
    logic        m_accept_reg, m_accept_next;
    logic [31:0] m_temp_reg, m_temp_next;
    logic        m_round_end_reg, m_round_end_next;
    logic [19:0] m_trials_reg, m_trials_next;
    logic [19:0] m_changes_reg, m_changes_next;
    logic        m_done_reg, m_done_next;

    logic [16:0] exp_rom [EXP_DEPTH];
    logic [16:0] rom_q_reg;

    logic [62:0]      mul_a;
    logic [63:0]      mul_sum;
    logic [63:0]      round_sum;
    logic [16:0]      rom_entry;
    logic             div_ge;
    logic [DIV_W-1:0] div_diff;
    logic [19:0]      trial_inc;
    logic [19:0]      change_inc;
    logic             round_close;
    logic             ratio_sat;
    logic             run_over;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);

    assign m_valid            = m_valid_reg;
    assign m_accept           = m_accept_reg;
    assign m_temperature_used = m_temp_reg;
    assign m_round_end        = m_round_end_reg;
    assign m_round_trials     = m_trials_reg;
    assign m_round_changes    = m_changes_reg;
    assign m_run_done         = m_done_reg;

    // shared shift-add multiplier: acc = (acc + b0*a) >> 1 keeps floor(a*b / 2^steps)
    assign mul_a   = (state_reg == ST_COOL) ? {31'b0, temp_reg} : p_reg;
    assign mul_sum = {1'b0, mul_acc_reg} + ({64{mul_b_reg[0]}} & {1'b0, mul_a});

    assign round_sum = {1'b0, p_reg} + EXP_HALF;
    assign rom_entry = round_sum[62:46];

    assign div_ge   = (rem_reg >= {1'b0, div_reg});
    assign div_diff = rem_reg - {1'b0, div_reg};

    // ratio saturates once delta*256 reaches T*depth
    assign ratio_sat = ({{SAT_SHIFT{1'b0}}, 1'b0, delta_reg}
                        >= {temp_reg, {SAT_SHIFT{1'b0}}});

    assign trial_inc   = trial_cnt_reg + 20'd1;
    assign change_inc  = change_cnt_reg + {19'b0, res_accept_reg};
    assign round_close = (trial_inc >= trials_lim_reg) || (change_inc >= changes_lim_reg);
    assign run_over    = (idle_rounds_reg >= IDLE_ROUND_LIMIT) || !(temp_reg > stop_temp_reg);

    always_comb begin
        state_next         = state_reg;
        start_temp_next    = start_temp_reg;
        stop_temp_next     = stop_temp_reg;
        cool_rate_next     = cool_rate_reg;
        trials_lim_next    = trials_lim_reg;
        changes_lim_next   = changes_lim_reg;
        temp_next          = temp_reg;
        trial_cnt_next     = trial_cnt_reg;
        change_cnt_next    = change_cnt_reg;
        idle_rounds_next   = idle_rounds_reg;
        finished_next      = finished_reg;
        delta_next         = delta_reg;
        rnd_next           = rnd_reg;
        rem_next           = rem_reg;
        div_next           = div_reg;
        ratio_next         = ratio_reg;
        step_cnt_next      = step_cnt_reg;
        p_next             = p_reg;
        fill_idx_next      = fill_idx_reg;
        mul_acc_next       = mul_acc_reg;
        mul_b_next         = mul_b_reg;
        res_accept_next    = res_accept_reg;
        res_temp_next      = res_temp_reg;
        res_round_end_next = res_round_end_reg;
        res_trials_next    = res_trials_reg;
        res_changes_next   = res_changes_reg;
        res_done_next      = res_done_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_accept_next      = m_accept_reg;
        m_temp_next        = m_temp_reg;
        m_round_end_next   = m_round_end_reg;
        m_trials_next      = m_trials_reg;
        m_changes_next     = m_changes_reg;
        m_done_next        = m_done_reg;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_START_TEMP:  start_temp_next  = cfg_data;
                CFG_STOP_TEMP:   stop_temp_next   = cfg_data;
                CFG_COOL_RATE:   cool_rate_next   = cfg_data[15:0];
                CFG_TRIALS_LIM:  trials_lim_next  = cfg_data[19:0];
                CFG_CHANGES_LIM: changes_lim_next = cfg_data[19:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_FILL_WR: begin
                if (fill_idx_reg == EXP_IDX_MAX) begin
                    state_next = ST_IDLE;
                end else begin
                    mul_acc_next  = '0;
                    mul_b_next    = EXP_STEP[61:0];
                    step_cnt_next = FILL_MUL_STEPS;
                    state_next    = ST_FILL_MUL;
                end
            end
            ST_FILL_MUL: begin
                mul_acc_next  = mul_sum[63:1];
                mul_b_next    = {1'b0, mul_b_reg[61:1]};
                step_cnt_next = step_cnt_reg - 6'd1;
                if (step_cnt_reg == 6'd1) begin
                    p_next        = mul_sum[63:1];
                    fill_idx_next = fill_idx_reg + 1'b1;
                    state_next    = ST_FILL_WR;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    delta_next         = s_energy_change[30:0];
                    rnd_next           = s_rand_value;
                    res_accept_next    = 1'b0;
                    res_temp_next      = temp_reg;
                    res_round_end_next = 1'b0;
                    res_trials_next    = '0;
                    res_changes_next   = '0;
                    res_done_next      = finished_reg;
                    if (s_cmd == CMD_RESTART) begin
                        temp_next        = start_temp_reg;
                        trial_cnt_next   = '0;
                        change_cnt_next  = '0;
                        idle_rounds_next = '0;
                        finished_next    = !(start_temp_reg > stop_temp_reg);
                        res_temp_next    = start_temp_reg;
                        res_done_next    = !(start_temp_reg > stop_temp_reg);
                        state_next       = ST_OUT;
                    end else if (finished_reg) begin
                        state_next = ST_OUT;
                    end else if (s_energy_change[31]) begin
                        res_accept_next = 1'b1;
                        state_next      = ST_COUNT;
                    end else begin
                        state_next = ST_RATIO;
                    end
                end
            end
            ST_RATIO: begin
                if (ratio_sat) begin
                    ratio_next = EXP_IDX_MAX;
                    state_next = ST_ROM_RD;
                end else begin
                    rem_next      = {{(EXP_IDX_W - EXP_FRAC_W + 1){1'b0}}, delta_reg,
                                     {EXP_FRAC_W{1'b0}}};
                    div_next      = {temp_reg, {(EXP_IDX_W - 1){1'b0}}};
                    ratio_next    = '0;
                    step_cnt_next = DIV_STEPS;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                // restoring division, one ratio bit per cycle
                if (div_ge) begin
                    rem_next = div_diff;
                end
                ratio_next    = {ratio_reg[EXP_IDX_W-2:0], div_ge};
                div_next      = {1'b0, div_reg[DIV_W-2:1]};
                step_cnt_next = step_cnt_reg - 6'd1;
                if (step_cnt_reg == 6'd1) begin
                    state_next = ST_ROM_RD;
                end
            end
            ST_ROM_RD: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                res_accept_next = (rnd_reg < rom_q_reg);
                state_next      = ST_COUNT;
            end
            ST_COUNT: begin
                if (!round_close) begin
                    trial_cnt_next  = trial_inc;
                    change_cnt_next = change_inc;
                    state_next      = ST_OUT;
                end else begin
                    res_round_end_next = 1'b1;
                    res_trials_next    = trial_inc;
                    res_changes_next   = change_inc;
                    trial_cnt_next     = '0;
                    change_cnt_next    = '0;
                    if (change_inc == 20'd0) begin
                        if (idle_rounds_reg < IDLE_ROUND_SAT) begin
                            idle_rounds_next = idle_rounds_reg + 3'd1;
                        end
                    end else begin
                        idle_rounds_next = '0;
                    end
                    mul_acc_next  = '0;
                    mul_b_next    = {46'b0, cool_rate_reg};
                    step_cnt_next = COOL_MUL_STEPS;
                    state_next    = ST_COOL;
                end
            end
            ST_COOL: begin
                mul_acc_next  = mul_sum[63:1];
                mul_b_next    = {1'b0, mul_b_reg[61:1]};
                step_cnt_next = step_cnt_reg - 6'd1;
                if (step_cnt_reg == 6'd1) begin
                    temp_next  = mul_sum[32:1];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (run_over) begin
                    finished_next = 1'b1;
                end
                res_done_next = finished_reg || run_over;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_accept_next    = res_accept_reg;
                    m_temp_next      = res_temp_reg;
                    m_round_end_next = res_round_end_reg;
                    m_trials_next    = res_trials_reg;
                    m_changes_next   = res_changes_reg;
                    m_done_next      = res_done_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_FILL_WR;
            start_temp_reg    <= RST_START_TEMP;
            stop_temp_reg     <= RST_STOP_TEMP;
            cool_rate_reg     <= RST_COOL_RATE;
            trials_lim_reg    <= RST_TRIALS_LIM;
            changes_lim_reg   <= RST_CHANGES_LIM;
            temp_reg          <= RST_START_TEMP;
            trial_cnt_reg     <= '0;
            change_cnt_reg    <= '0;
            idle_rounds_reg   <= '0;
            finished_reg      <= 1'b1;
            delta_reg         <= '0;
            rnd_reg           <= '0;
            rem_reg           <= '0;
            div_reg           <= '0;
            ratio_reg         <= '0;
            step_cnt_reg      <= '0;
            p_reg             <= EXP_ONE[62:0];
            fill_idx_reg      <= '0;
            mul_acc_reg       <= '0;
            mul_b_reg         <= '0;
            res_accept_reg    <= 1'b0;
            res_temp_reg      <= '0;
            res_round_end_reg <= 1'b0;
            res_trials_reg    <= '0;
            res_changes_reg   <= '0;
            res_done_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
            m_accept_reg      <= 1'b0;
            m_temp_reg        <= '0;
            m_round_end_reg   <= 1'b0;
            m_trials_reg      <= '0;
            m_changes_reg     <= '0;
            m_done_reg        <= 1'b0;
        end else begin
            state_reg         <= state_next;
            start_temp_reg    <= start_temp_next;
            stop_temp_reg     <= stop_temp_next;
            cool_rate_reg     <= cool_rate_next;
            trials_lim_reg    <= trials_lim_next;
            changes_lim_reg   <= changes_lim_next;
            temp_reg          <= temp_next;
            trial_cnt_reg     <= trial_cnt_next;
            change_cnt_reg    <= change_cnt_next;
            idle_rounds_reg   <= idle_rounds_next;
            finished_reg      <= finished_next;
            delta_reg         <= delta_next;
            rnd_reg           <= rnd_next;
            rem_reg           <= rem_next;
            div_reg           <= div_next;
            ratio_reg         <= ratio_next;
            step_cnt_reg      <= step_cnt_next;
            p_reg             <= p_next;
            fill_idx_reg      <= fill_idx_next;
            mul_acc_reg       <= mul_acc_next;
            mul_b_reg         <= mul_b_next;
            res_accept_reg    <= res_accept_next;
            res_temp_reg      <= res_temp_next;
            res_round_end_reg <= res_round_end_next;
            res_trials_reg    <= res_trials_next;
            res_changes_reg   <= res_changes_next;
            res_done_reg      <= res_done_next;
            m_valid_reg       <= m_valid_next;
            m_accept_reg      <= m_accept_next;
            m_temp_reg        <= m_temp_next;
            m_round_end_reg   <= m_round_end_next;
            m_trials_reg      <= m_trials_next;
            m_changes_reg     <= m_changes_next;
            m_done_reg        <= m_done_next;
        end
    end

    // exponential table, filled once after reset
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FILL_WR) begin
            exp_rom[fill_idx_reg] <= rom_entry;
        end
        if (state_reg == ST_ROM_RD) begin
            rom_q_reg <= exp_rom[ratio_reg];
        end
    end

endmodule

>>> bench/annealing_acceptance_scheduler_unit_tb.sv
// testbench for the annealing acceptance scheduler: metropolis decisions checked against a predictor
`timescale 1ns / 1ps

module annealing_acceptance_scheduler_unit_tb;
    import aas_pkg::*;

    localparam int unsigned EXP_ENTRIES = 4096;
    localparam logic [11:0] EXP_LAST    = 12'd4095;
    localparam logic [2:0]  IDLE_LIMIT  = 3'd5;
    localparam logic [2:0]  IDLE_SAT    = 3'd7;
    localparam logic [2:0]  CFG_UNUSED  = 3'd5;
    localparam longint unsigned LIMIT_NS = 64'd8_000_000;

    typedef struct packed {
        logic        accept;
        logic [31:0] temp_used;
        logic        round_end;
        logic [19:0] round_trials;
        logic [19:0] round_changes;
        logic        run_done;
    } decision_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic               s_cmd;
    logic signed [31:0] s_energy_change;
    logic [16:0]        s_rand_value;
    logic               m_valid;
    logic               m_ready;
    logic               m_accept;
    logic [31:0]        m_temperature_used;
    logic               m_round_end;
    logic [19:0]        m_round_trials;
    logic [19:0]        m_round_changes;
    logic               m_run_done;

    annealing_acceptance_scheduler_unit u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cmd              (s_cmd),
        .s_energy_change    (s_energy_change),
        .s_rand_value       (s_rand_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_accept           (m_accept),
        .m_temperature_used (m_temperature_used),
        .m_round_end        (m_round_end),
        .m_round_trials     (m_round_trials),
        .m_round_changes    (m_round_changes),
        .m_run_done         (m_run_done)
    );

    // predictor copy of the configuration and the annealing state
    logic [31:0] cfg_start;
    logic [31:0] cfg_stop;
    logic [15:0] cfg_rate;
    logic [19:0] cfg_trials;
    logic [19:0] cfg_changes;
    logic [31:0] temp;
    logic [19:0] n_trials;
    logic [19:0] n_changes;
    logic [2:0]  idle_cnt;
    logic        run_finished;
    logic [16:0] exp_tab [EXP_ENTRIES];

    decision_t   pending_decisions [$];
    int unsigned mismatches;
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned sink_hold;

    always #2 aclk = ~aclk;

    // exp(-k/256) in q2.62 by truncating series and products, rounded to 16 bits
    function automatic void build_exp_tab();
        logic [63:0]  term;
        logic [63:0]  q_step;
        logic [63:0]  p;
        logic [127:0] prod;
        term   = 64'd1 << 62;
        q_step = term;
        p      = term;
        for (int n = 1; n <= 8; n++) begin
            term = term / (64'd256 * 64'(n));
            if (n % 2 == 1) q_step = q_step - term;
            else q_step = q_step + term;
        end
        for (int k = 0; k < EXP_ENTRIES; k++) begin
            exp_tab[k] = 17'((p + (64'd1 << 45)) >> 46);
            prod = 128'(p) * 128'(q_step);
            p = 64'(prod >> 62);
        end
    endfunction

    function automatic logic [11:0] exp_index(input logic [31:0] de);
        logic [39:0] quot;
        if (temp == 32'd0) return EXP_LAST;
        quot = {de, 8'd0} / 40'(temp);
        return (quot < 40'(EXP_LAST)) ? quot[11:0] : EXP_LAST;
    endfunction

    // smallest non-negative change whose ratio reaches r at the current temperature
    function automatic logic [31:0] change_for_ratio(input int unsigned r);
        logic [63:0] v;
        v = (64'(r) * 64'(temp) + 64'd255) >> 8;
        if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
        return v[31:0];
    endfunction

    function automatic decision_t metropolis_step(input logic cmd, input logic [31:0] de,
                                                  input logic [16:0] rnd);
        decision_t   d;
        logic [47:0] cooled;
        d = '0;
        d.temp_used = temp;
        if (cmd == CMD_RESTART) begin
            temp         = cfg_start;
            n_trials     = '0;
            n_changes    = '0;
            idle_cnt     = '0;
            run_finished = !(temp > cfg_stop);
            d.temp_used  = temp;
        end else if (!run_finished) begin
            if (de[31]) d.accept = 1'b1;
            else d.accept = rnd < exp_tab[exp_index(de)];
            n_trials = n_trials + 20'd1;
            if (d.accept) n_changes = n_changes + 20'd1;
            if (n_trials >= cfg_trials || n_changes >= cfg_changes) begin
                d.round_end     = 1'b1;
                d.round_trials  = n_trials;
                d.round_changes = n_changes;
                if (n_changes == '0) begin
                    if (idle_cnt != IDLE_SAT) idle_cnt = idle_cnt + 3'd1;
                end else begin
                    idle_cnt = '0;
                end
                cooled    = 48'(temp) * 48'(cfg_rate);
                temp      = cooled[47:16];
                n_trials  = '0;
                n_changes = '0;
                if (idle_cnt >= IDLE_LIMIT || !(temp > cfg_stop)) run_finished = 1'b1;
            end
        end
        d.run_done = run_finished;
        return d;
    endfunction

    // result side: check each item against the oldest prediction, then pick next ready
    always @(posedge aclk) begin : result_check
        decision_t got;
        decision_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_accept, m_temperature_used, m_round_end, m_round_trials,
                    m_round_changes, m_run_done};
            if (pending_decisions.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: result item with no decision pending", $realtime);
                mismatches++;
            end else begin
                want = pending_decisions.pop_front();
                if (got.accept !== want.accept || got.temp_used !== want.temp_used ||
                    got.round_end !== want.round_end ||
                    got.round_trials !== want.round_trials ||
                    got.round_changes !== want.round_changes ||
                    got.run_done !== want.run_done) begin
                    if (mismatches < 10)
                        $display("%0t: decision mismatch: expected acc=%0d t=%0d end=%0d tr=%0d ch=%0d done=%0d, actual acc=%0d t=%0d end=%0d tr=%0d ch=%0d done=%0d",
                                 $realtime, want.accept, want.temp_used, want.round_end,
                                 want.round_trials, want.round_changes, want.run_done,
                                 got.accept, got.temp_used, got.round_end,
                                 got.round_trials, got.round_changes, got.run_done);
                    mismatches++;
                end
            end
        end
        if (sink_hold > 0) begin
            m_ready <= 1'b0;
            sink_hold = sink_hold - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic write_cfg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_START_TEMP:  cfg_start   = data;
            CFG_STOP_TEMP:   cfg_stop    = data;
            CFG_COOL_RATE:   cfg_rate    = data[15:0];
            CFG_TRIALS_LIM:  cfg_trials  = data[19:0];
            CFG_CHANGES_LIM: cfg_changes = data[19:0];
            default: ;
        endcase
    endtask

    // every register, plus one write to an unused index that must be ignored
    task automatic configure(input logic [31:0] start, input logic [31:0] stop,
                             input logic [15:0] rate, input logic [19:0] trials,
                             input logic [19:0] changes);
        write_cfg(CFG_START_TEMP, start);
        write_cfg(CFG_STOP_TEMP, stop);
        write_cfg(CFG_COOL_RATE, {16'($urandom), rate});
        write_cfg(CFG_TRIALS_LIM, {12'($urandom), trials});
        write_cfg(CFG_CHANGES_LIM, {12'($urandom), changes});
        write_cfg(CFG_UNUSED + 3'($urandom_range(0, 2)), $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure_random();
        logic [31:0] start;
        case ($urandom_range(9))
            0: configure(32'hFFFF_FFFF, 32'd0, 16'hFFFF, 20'hFFFFF, 20'hFFFFF);
            1: configure($urandom, $urandom, 16'($urandom), 20'd0, 20'd0);
            2: configure($urandom_range(1, 4000), 32'd0, 16'd1, 20'($urandom_range(1, 8)),
                         20'($urandom_range(1, 4)));
            3: configure(32'd0, 32'd0, 16'd0, 20'd3, 20'd2);
            default: begin
                start = $urandom_range(300, 2_000_000);
                configure(start, $urandom_range(0, start >> 6),
                          16'($urandom_range(20000, 64000)),
                          20'($urandom_range(1, 24)), 20'($urandom_range(1, 12)));
            end
        endcase
    endtask

    // valid stays high between back-to-back items; lowered only for a gap
    task automatic send_item(input logic cmd, input logic [31:0] de, input logic [16:0] rnd);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_cmd           <= cmd;
        s_energy_change <= de;
        s_rand_value    <= rnd;
        do @(posedge aclk); while (!s_ready);
        pending_decisions.push_back(metropolis_step(cmd, de, rnd));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_decisions.size() != 0);
    endtask

    task automatic send_random_trial();
        logic [31:0] de;
        logic [16:0] rnd;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 20) de = {1'b1, 31'($urandom)};
        else if (pick < 70)
            de = change_for_ratio($urandom_range(0, ($urandom_range(3) == 0) ? 4400 : 900));
        else if (pick < 80) de = 32'($urandom_range(0, 3));
        else de = {1'b0, 31'($urandom)};
        case ($urandom_range(9))
            0, 1, 2: rnd = exp_tab[exp_index(de)] + 17'($urandom_range(0, 2)) - 17'd1;
            3:       rnd = 17'($urandom_range(65536, 131071));
            4:       rnd = 17'($urandom);
            default: rnd = 17'($urandom_range(0, 65536));
        endcase
        send_item(CMD_TRIAL, de, rnd);
    endtask

    task automatic test_reset_defaults();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        // run counts as done out of reset until the first restart
        send_item(CMD_TRIAL, 32'd5, 17'd0);
        send_item(CMD_RESTART, 32'd0, 17'd0);
        send_item(CMD_TRIAL, 32'd0, 17'd65535);
        wait_drained();
    endtask

    task automatic test_directed_cases();
        logic [31:0] de;
        src_idle_pct  = 0;
        sink_idle_pct = 30;
        configure(32'd1000, 32'd10, 16'd32768, 20'd4, 20'd2);
        send_item(CMD_RESTART, 32'hFFFF_FFFF, 17'h1FFFF);
        send_item(CMD_TRIAL, 32'd0, 17'd0);
        // random of exactly one never beats the top table entry
        send_item(CMD_TRIAL, 32'd0, 17'd65536);
        send_item(CMD_TRIAL, 32'hFFFF_FFFF, 17'h1FFFF);
        send_item(CMD_TRIAL, 32'h8000_0000, 17'h1FFFF);
        send_item(CMD_TRIAL, 32'h7FFF_FFFF, 17'd0);
        de = change_for_ratio(300);
        send_item(CMD_TRIAL, de, exp_tab[exp_index(de)] - 17'd1);
        send_item(CMD_TRIAL, de, exp_tab[exp_index(de)]);
        send_item(CMD_TRIAL, 32'd1, 17'd65537);
        wait_drained();

        // start not above stop: done right at restart, later trials ignored
        configure(32'd500, 32'd500, 16'd1, 20'd0, 20'd0);
        send_item(CMD_RESTART, 32'd0, 17'd0);
        send_item(CMD_TRIAL, 32'hFFFF_FFFF, 17'd0);
        wait_drained();

        // zero round limits close every round, cooling collapses to zero
        configure(32'd1, 32'd0, 16'd0, 20'd0, 20'd0);
        send_item(CMD_RESTART, 32'd0, 17'd0);
        send_item(CMD_TRIAL, 32'd0, 17'd0);
        send_item(CMD_TRIAL, 32'd0, 17'd0);
        wait_drained();

        // rounds with no accepted change end the run
        configure(32'hFFFF_FFFF, 32'd0, 16'hFFFF, 20'd1, 20'hFFFFF);
        send_item(CMD_RESTART, 32'd0, 17'd0);
        repeat (6) send_item(CMD_TRIAL, 32'h7FFF_FFFF, 17'd65536);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int unsigned n, input int unsigned src_pct,
                                       input int unsigned sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int i = 0; i < n; i++) begin
            if (i % 140 == 0) begin
                wait_drained();
                configure_random();
            end
            if ($urandom_range(99) < (run_finished ? 75 : 2))
                send_item(CMD_RESTART, $urandom, 17'($urandom));
            else
                send_random_trial();
        end
        wait_drained();
    endtask

    // long receiver stall while items keep coming, so the input backs up
    task automatic test_output_hold_off();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        configure(32'd100000, 32'd0, 16'd60000, 20'd6, 20'd3);
        send_item(CMD_RESTART, 32'd0, 17'd0);
        sink_hold = 400;
        repeat (16) send_random_trial();
        wait_drained();
    endtask

    initial begin
        aclk            = 1'b0;
        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        s_valid         = 1'b0;
        s_cmd           = CMD_RESTART;
        s_energy_change = '0;
        s_rand_value    = '0;
        m_ready         = 1'b0;
        mismatches      = 0;
        sink_hold       = 0;
        src_idle_pct    = 0;
        sink_idle_pct   = 0;
        cfg_start       = 32'd1000000;
        cfg_stop        = 32'd1;
        cfg_rate        = 16'd58982;
        cfg_trials      = 20'd100000;
        cfg_changes     = 20'd1000;
        temp            = cfg_start;
        n_trials        = '0;
        n_changes       = '0;
        idle_cnt        = '0;
        run_finished    = 1'b1;
        build_exp_tab();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_directed_cases();
        test_random_traffic(560, 16, 87);
        test_output_hold_off();
        test_random_traffic(560, 87, 16);
        test_random_traffic(560, 0, 0);

        repeat (50) @(posedge aclk);
        if (mismatches == 0 && pending_decisions.size() == 0)
            $display("annealing_acceptance_scheduler_unit_tb: PASS");
        else
            $display("annealing_acceptance_scheduler_unit_tb: FAIL");
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("annealing_acceptance_scheduler_unit_tb: FAIL");
        $finish;
    end

endmodule
